>>> rtl/pp_pkg.sv
// ----------------------------------------------------------------------------
// Perspective projection package
// Widths, codes and the pipeline side-band type shared by the projection
// datapath and its divider.
// ----------------------------------------------------------------------------
package pp_pkg;

   localparam int CW          = 50;
   localparam int NUM_W       = 64;
   localparam int QBITS       = 41;
   localparam int DW          = CW + QBITS;
   localparam int CFG_W       = 14;
   localparam int CSR_IDX_W   = 2;
   localparam int VIS_THRESHOLD = 6554;

   localparam logic       CMD_LOAD    = 1'b0;
   localparam logic       CMD_PROJECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd1024;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd768;

   typedef struct packed {
      logic valid;
      logic vis;
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } side_type;

endpackage

>>> rtl/perspective_projection.sv
// ----------------------------------------------------------------------------
// Perspective projection
// World point to screen coordinates through a 4x4 matrix, in Q16.16.
// ----------------------------------------------------------------------------
// Requests arrive on req_ with valid and ready. A request with command load
// writes one matrix entry and gives no response; a project request gives one
// response on rsp_ with the visible flag and the saturated screen position.
// The screen width and height are set through the csr_ write channel, which
// is always ready and is meant to be written while the block is idle.
// The pipeline takes one request per cycle while the receiver does not stall.
// A request passes through one stage of products, one of clip sums, one of
// preparation, 41 stages of the restoring divider (one quotient bit each),
// one of viewport scaling and the output register.
// When the receiver stalls, the whole pipeline holds and req_ready drops in
// the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and the matrix, and sets the viewport to
// 1024 by 768.
// ----------------------------------------------------------------------------
module perspective_projection (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [3:0]                        req_matrix_index,
   input  logic signed [31:0]                req_matrix_value,
   input  logic signed [31:0]                req_pos_x,
   input  logic signed [31:0]                req_pos_y,
   input  logic signed [31:0]                req_pos_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_visible,
   output logic signed [31:0]                rsp_screen_x,
   output logic signed [31:0]                rsp_screen_y,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pp_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int CW = pp_pkg::CW;
   localparam int QB = pp_pkg::QBITS;
   localparam logic [QB-1:0] NDC_LIMIT = QB'(1) << (QB - 1);

   logic en, accept;
   logic [pp_pkg::CFG_W-1:0] width_ff, height_ff;
   logic signed [31:0] mat_ff [0:15];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pp_pkg::WIDTH_RESET;
         height_ff <= pp_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pp_pkg::REG_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            pp_pkg::REG_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) mat_ff[i] <= '0;
      end else if (accept && req_command == pp_pkg::CMD_LOAD) begin
         mat_ff[req_matrix_index] <= req_matrix_value;
      end
   end

   // Stage 1: products of the point with the matrix rows.
   logic signed [63:0] prod_ff [0:8];
   logic signed [31:0] tx_ff, ty_ff, tw_ff;
   logic               v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept && req_command == pp_pkg::CMD_PROJECT;
      end
      if (en) begin
         prod_ff[0] <= req_pos_x * mat_ff[0];
         prod_ff[1] <= req_pos_y * mat_ff[4];
         prod_ff[2] <= req_pos_z * mat_ff[8];
         prod_ff[3] <= req_pos_x * mat_ff[1];
         prod_ff[4] <= req_pos_y * mat_ff[5];
         prod_ff[5] <= req_pos_z * mat_ff[9];
         prod_ff[6] <= req_pos_x * mat_ff[3];
         prod_ff[7] <= req_pos_y * mat_ff[7];
         prod_ff[8] <= req_pos_z * mat_ff[11];
         tx_ff <= mat_ff[12];
         ty_ff <= mat_ff[13];
         tw_ff <= mat_ff[15];
      end
   end

   // Stage 2: floored products summed into clip coordinates.
   logic signed [CW-1:0] cx_ff, cy_ff, cw_ff;
   logic                 v2_ff;
   logic signed [47:0]   fl [0:8];

   always_comb begin
      for (int i = 0; i < 9; i++) fl[i] = 48'(prod_ff[i] >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         cx_ff <= CW'(fl[0]) + CW'(fl[1]) + CW'(fl[2]) + CW'(tx_ff);
         cy_ff <= CW'(fl[3]) + CW'(fl[4]) + CW'(fl[5]) + CW'(ty_ff);
         cw_ff <= CW'(fl[6]) + CW'(fl[7]) + CW'(fl[8]) + CW'(tw_ff);
      end
   end

   // Stage 3: magnitudes, visibility and quotient overflow.
   logic [CW-1:0]            mag_x, mag_y;
   logic [pp_pkg::NUM_W-1:0] nx_c, ny_c;
   logic [pp_pkg::DW-1:0]    wlim;
   logic [pp_pkg::NUM_W-1:0] nx_ff, ny_ff;
   logic [CW-1:0]            den_ff;
   pp_pkg::side_type         s3_ff;

   assign mag_x = cx_ff[CW-1] ? CW'(-cx_ff) : CW'(cx_ff);
   assign mag_y = cy_ff[CW-1] ? CW'(-cy_ff) : CW'(cy_ff);
   assign nx_c  = pp_pkg::NUM_W'({mag_x, 16'b0});
   assign ny_c  = pp_pkg::NUM_W'({mag_y, 16'b0});
   assign wlim  = pp_pkg::DW'(cw_ff) << QB;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ff.valid <= v2_ff;
      end
      if (en) begin
         nx_ff       <= nx_c;
         ny_ff       <= ny_c;
         den_ff      <= cw_ff;
         s3_ff.vis   <= cw_ff >= CW'(pp_pkg::VIS_THRESHOLD);
         s3_ff.neg_x <= cx_ff[CW-1];
         s3_ff.neg_y <= cy_ff[CW-1];
         s3_ff.ovf_x <= pp_pkg::DW'(nx_c) >= wlim;
         s3_ff.ovf_y <= pp_pkg::DW'(ny_c) >= wlim;
      end
   end

   logic [QB-1:0]    qx, qy;
   pp_pkg::side_type sd;

   pp_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .num_x    (nx_ff),
      .num_y    (ny_ff),
      .den      (den_ff),
      .side_in  (s3_ff),
      .quo_x    (qx),
      .quo_y    (qy),
      .side_out (sd)
   );

   // Scaling stage: clamp the NDC values and multiply by the half sizes.
   logic [QB-1:0]          qxc, qyc;
   logic signed [QB:0]     ndx, ndy;
   logic signed [13:0]     hw_s, hh_s;
   logic signed [QB+14:0]  px_ff, py_ff;
   logic                   v5_ff, vis5_ff;

   assign qxc  = (sd.ovf_x || qx > NDC_LIMIT) ? NDC_LIMIT : qx;
   assign qyc  = (sd.ovf_y || qy > NDC_LIMIT) ? NDC_LIMIT : qy;
   assign ndx  = sd.neg_x ? -$signed({1'b0, qxc}) : $signed({1'b0, qxc});
   assign ndy  = sd.neg_y ? -$signed({1'b0, qyc}) : $signed({1'b0, qyc});
   assign hw_s = $signed({1'b0, width_ff[pp_pkg::CFG_W-1:1]});
   assign hh_s = $signed({1'b0, height_ff[pp_pkg::CFG_W-1:1]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= sd.valid;
      end
      if (en) begin
         vis5_ff <= sd.vis;
         px_ff   <= hw_s * ndx;
         py_ff   <= hh_s * ndy;
      end
   end

   // Output stage: add the viewport center, saturate and zero hidden points.
   logic signed [QB+16:0] sum_x, sum_y;
   logic signed [31:0]    sat_x, sat_y;
   logic signed [QB+16:0] smax, smin;

   assign smax  = $signed((QB+17)'(32'h7FFF_FFFF));
   assign smin  = -smax - (QB+17)'(1);
   assign sum_x = (QB+17)'(px_ff) + (QB+17)'({width_ff[pp_pkg::CFG_W-1:1], 16'b0});
   assign sum_y = (QB+17)'({height_ff[pp_pkg::CFG_W-1:1], 16'b0}) - (QB+17)'(py_ff);
   assign sat_x = (sum_x > smax) ? 32'sh7FFF_FFFF :
                  (sum_x < smin) ? 32'sh8000_0000 : 32'(sum_x);
   assign sat_y = (sum_y > smax) ? 32'sh7FFF_FFFF :
                  (sum_y < smin) ? 32'sh8000_0000 : 32'(sum_y);

   logic               rsp_valid_ff, vis_ff;
   logic signed [31:0] sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v5_ff;
      end
      if (en) begin
         vis_ff <= vis5_ff;
         sx_ff  <= vis5_ff ? sat_x : '0;
         sy_ff  <= vis5_ff ? sat_y : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = vis_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;

endmodule

>>> rtl/pp_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined dual divider
// Restoring division of two magnitudes by a shared divisor, one quotient bit
// per register stage, with side-band status carried alongside.
// ----------------------------------------------------------------------------
module pp_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [pp_pkg::NUM_W-1:0]      num_x,
   input  logic [pp_pkg::NUM_W-1:0]      num_y,
   input  logic [pp_pkg::CW-1:0]         den,
   input  pp_pkg::side_type              side_in,
   output logic [pp_pkg::QBITS-1:0]      quo_x,
   output logic [pp_pkg::QBITS-1:0]      quo_y,
   output pp_pkg::side_type              side_out
);

   localparam int QB = pp_pkg::QBITS;

   logic [pp_pkg::NUM_W-1:0] rx_ff [0:QB-1];
   logic [pp_pkg::NUM_W-1:0] ry_ff [0:QB-1];
   logic [QB-1:0]            qx_ff [0:QB-1];
   logic [QB-1:0]            qy_ff [0:QB-1];
   logic [pp_pkg::CW-1:0]    w_ff  [0:QB-1];
   pp_pkg::side_type         sd_ff [0:QB-1];

   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int B = QB - 1 - k;
      logic [pp_pkg::NUM_W-1:0] rx_cur, ry_cur;
      logic [QB-1:0]            qx_cur, qy_cur;
      logic [pp_pkg::CW-1:0]    w_cur;
      pp_pkg::side_type         sd_cur;
      logic [pp_pkg::DW-1:0]    dsh, rxe, rye;
      logic                     gx, gy;

      if (k == 0) begin : g_first
         assign rx_cur = num_x;
         assign ry_cur = num_y;
         assign qx_cur = '0;
         assign qy_cur = '0;
         assign w_cur  = den;
         assign sd_cur = side_in;
      end else begin : g_next
         assign rx_cur = rx_ff[k-1];
         assign ry_cur = ry_ff[k-1];
         assign qx_cur = qx_ff[k-1];
         assign qy_cur = qy_ff[k-1];
         assign w_cur  = w_ff[k-1];
         assign sd_cur = sd_ff[k-1];
      end

      assign dsh = pp_pkg::DW'(w_cur) << B;
      assign rxe = pp_pkg::DW'(rx_cur);
      assign rye = pp_pkg::DW'(ry_cur);
      assign gx  = rxe >= dsh;
      assign gy  = rye >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[k].valid <= 1'b0;
         end else if (en) begin
            sd_ff[k].valid <= sd_cur.valid;
         end
         if (en) begin
            rx_ff[k] <= gx ? pp_pkg::NUM_W'(rxe - dsh) : rx_cur;
            ry_ff[k] <= gy ? pp_pkg::NUM_W'(rye - dsh) : ry_cur;
            qx_ff[k] <= qx_cur | (QB'(gx) << B);
            qy_ff[k] <= qy_cur | (QB'(gy) << B);
            w_ff[k]  <= w_cur;
            sd_ff[k].vis   <= sd_cur.vis;
            sd_ff[k].neg_x <= sd_cur.neg_x;
            sd_ff[k].neg_y <= sd_cur.neg_y;
            sd_ff[k].ovf_x <= sd_cur.ovf_x;
            sd_ff[k].ovf_y <= sd_cur.ovf_y;
         end
      end
   end

   assign quo_x    = qx_ff[QB-1];
   assign quo_y    = qy_ff[QB-1];
   assign side_out = sd_ff[QB-1];

endmodule

>>> rtl/pp_checker.sv
// ----------------------------------------------------------------------------
// Perspective projection checker
// Port-level properties of the projection block, bound to its top level.
// ----------------------------------------------------------------------------
module pp_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_visible,
   input  logic signed [31:0]           rsp_screen_x,
   input  logic signed [31:0]           rsp_screen_y
);

   // A response is never shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A hidden point always reports the origin.
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == 0 && rsp_screen_y == 0)
      else $error("hidden point with nonzero position");

   // A stalled response blocks new requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted during stall");

   // A stalled response holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_visible))
      else $error("stalled response changed");

endmodule

bind perspective_projection pp_checker u_pp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_visible  (rsp_visible),
   .rsp_screen_x (rsp_screen_x),
   .rsp_screen_y (rsp_screen_y)
);

>>> test/perspective_projection_tb.sv
// ----------------------------------------------------------------------------
// Perspective projection testbench
// Loads view-projection matrices, projects points under several viewport
// settings and checks every response against a Q16.16 projection predictor.
// Both channels idle and stall at random, except in the last phase.
// ----------------------------------------------------------------------------
module perspective_projection_tb;

   typedef struct {
      logic              visible;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
   } point_result_type;

   class projection_scoreboard;
      logic signed [31:0]       matrix [16];
      logic [pp_pkg::CFG_W-1:0] width_reg;
      logic [pp_pkg::CFG_W-1:0] height_reg;
      point_result_type         expected_points [$];
      int                       mismatches;

      function new();
         foreach (matrix[i]) matrix[i] = '0;
         width_reg  = pp_pkg::WIDTH_RESET;
         height_reg = pp_pkg::HEIGHT_RESET;
         mismatches = 0;
      endfunction

      function void write_register(logic [pp_pkg::CSR_IDX_W-1:0] idx,
                                   logic [pp_pkg::CFG_W-1:0] data);
         if (idx == pp_pkg::REG_SCREEN_WIDTH) width_reg = data;
         else if (idx == pp_pkg::REG_SCREEN_HEIGHT) height_reg = data;
      endfunction

      function longint fixed_mul(logic signed [31:0] a, logic signed [31:0] b);
         longint p;
         p = longint'(a) * longint'(b);
         return p >>> 16;
      endfunction

      function longint ndc_quotient(longint num, longint w);
         logic [95:0] mag;
         logic [95:0] q;
         mag = (num < 0) ? 96'(-num) : 96'(num);
         q = (mag << 16) / 96'(w);
         if (q > (96'd1 << 40)) q = 96'd1 << 40;
         return (num < 0) ? -longint'(q) : longint'(q);
      endfunction

      function logic signed [31:0] saturate(longint v);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      function point_result_type project_point(logic signed [31:0] px,
                                               logic signed [31:0] py,
                                               logic signed [31:0] pz);
         point_result_type r;
         longint cx, cy, cw, hw, hh;
         cx = fixed_mul(px, matrix[0]) + fixed_mul(py, matrix[4]) + fixed_mul(pz, matrix[8])
              + longint'(matrix[12]);
         cy = fixed_mul(px, matrix[1]) + fixed_mul(py, matrix[5]) + fixed_mul(pz, matrix[9])
              + longint'(matrix[13]);
         cw = fixed_mul(px, matrix[3]) + fixed_mul(py, matrix[7]) + fixed_mul(pz, matrix[11])
              + longint'(matrix[15]);
         if (cw < pp_pkg::VIS_THRESHOLD) begin
            r.visible  = 1'b0;
            r.screen_x = '0;
            r.screen_y = '0;
         end else begin
            hw = longint'(width_reg >> 1);
            hh = longint'(height_reg >> 1);
            r.visible  = 1'b1;
            r.screen_x = saturate(hw * ndc_quotient(cx, cw) + hw * 65536);
            r.screen_y = saturate(-(hh * ndc_quotient(cy, cw)) + hh * 65536);
         end
         return r;
      endfunction

      function void note_request(logic cmd, logic [3:0] idx, logic signed [31:0] val,
                                 logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
         if (cmd == pp_pkg::CMD_LOAD) matrix[idx] = val;
         else expected_points.push_back(project_point(px, py, pz));
      endfunction

      function void check_response(logic vis, logic signed [31:0] sx, logic signed [31:0] sy);
         point_result_type e;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: visible=%0b x=%0d y=%0d", vis, sx, sy);
            return;
         end
         e = expected_points.pop_front();
         if (vis !== e.visible || sx !== e.screen_x || sy !== e.screen_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected visible=%0b x=%0d y=%0d, got visible=%0b x=%0d y=%0d",
                        e.visible, e.screen_x, e.screen_y, vis, sx, sy);
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = pp_pkg::CMD_LOAD;
   logic [3:0]                   req_matrix_index = '0;
   logic signed [31:0]           req_matrix_value = '0;
   logic signed [31:0]           req_pos_x = '0;
   logic signed [31:0]           req_pos_y = '0;
   logic signed [31:0]           req_pos_z = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_visible;
   logic signed [31:0]           rsp_screen_x;
   logic signed [31:0]           rsp_screen_y;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [pp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pp_pkg::CFG_W-1:0]     csr_wdata = '0;

   projection_scoreboard scoreboard = new();
   bit                   calm = 1'b0;
   int                   cycle_count = 0;
   int                   stall_left = 0;

   perspective_projection i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_response(rsp_visible, rsp_screen_x, rsp_screen_y);
   end

   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic signed [31:0] random_fixed();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'sh7FFFFFFF;
         2: return 32'sh80000000;
         3: return '0;
         default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
      endcase
   endfunction

   task automatic send_request(logic cmd, logic [3:0] idx, logic signed [31:0] val,
                               logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_matrix_index <= idx;
      req_matrix_value <= val;
      req_pos_x        <= px;
      req_pos_y        <= py;
      req_pos_z        <= pz;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_request(cmd, idx, val, px, py, pz);
   endtask

   task automatic load_entry(logic [3:0] idx, logic signed [31:0] val);
      send_request(pp_pkg::CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
   endtask

   task automatic project(logic signed [31:0] px, logic signed [31:0] py,
                          logic signed [31:0] pz);
      send_request(pp_pkg::CMD_PROJECT, 4'($urandom), $urandom, px, py, pz);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.expected_points.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [pp_pkg::CSR_IDX_W-1:0] idx,
                            logic [pp_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      scoreboard.write_register(idx, data);
   endtask

   task automatic load_perspective();
      for (int i = 0; i < 16; i++) load_entry(4'(i), '0);
      load_entry(4'd0, $signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      load_entry(4'd5, $signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      load_entry(4'd4, random_fixed());
      load_entry(4'd12, random_fixed());
      load_entry(4'd13, random_fixed());
      load_entry(4'd11, $urandom_range(0, 32'h20000));
      load_entry(4'd15, $urandom_range(0, 32'h30000));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      project(32'sh00010000, 32'sh00010000, 32'sh00010000);
      for (int i = 0; i < 16; i++)
         load_entry(4'(i), (i % 5 == 0) ? 32'sh00010000 : 32'sh0);
      load_entry(4'd15, 32'sh00001999);
      project(0, 0, 0);
      load_entry(4'd15, 32'sh0000199A);
      project(0, 0, 0);
      project(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      project(32'sh80000000, 32'sh80000000, 32'sh80000000);
      load_entry(4'd3, 32'sh80000000);
      project(32'sh00010000, 0, 0);
      project(32'sh80000000, 0, 0);
      load_entry(4'd3, 32'sh7FFFFFFF);
      load_entry(4'd15, 32'sh80000000);
      project(32'sh7FFFFFFF, 32'sh12345678, 32'sh80000000);
      project(32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh00000001);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin write_csr(pp_pkg::REG_SCREEN_WIDTH, 14'd0);
                     write_csr(pp_pkg::REG_SCREEN_HEIGHT, 14'd1); end
            2: begin write_csr(pp_pkg::REG_SCREEN_WIDTH, 14'd8192);
                     write_csr(pp_pkg::REG_SCREEN_HEIGHT, 14'd16383);
                     write_csr(2'd2, 14'd5); write_csr(2'd3, 14'd7); end
            3: begin write_csr(pp_pkg::REG_SCREEN_WIDTH, 14'd16383);
                     write_csr(pp_pkg::REG_SCREEN_HEIGHT, 14'd1); end
            4: begin write_csr(pp_pkg::REG_SCREEN_WIDTH, 14'($urandom));
                     write_csr(pp_pkg::REG_SCREEN_HEIGHT, 14'($urandom)); end
            5: begin write_csr(pp_pkg::REG_SCREEN_WIDTH, 14'd640);
                     write_csr(pp_pkg::REG_SCREEN_HEIGHT, 14'd480);
                     calm = 1'b1; end
            default: ;
         endcase
         csr_valid <= 1'b0;
         load_perspective();
         for (int n = 0; n < 18; n++) begin
            case ($urandom_range(0, 9))
               0: load_entry(4'($urandom), random_fixed());
               1: load_perspective();
               2: project($urandom, $urandom, $urandom);
               default: project(random_fixed(), random_fixed(), random_fixed());
            endcase
            if (phase == 2 && n == 9) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (scoreboard.expected_points.size() != 0);
            end
         end
         drain();
      end

      if (scoreboard.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
